FILE: src/cclm_pkg.sv
package cclm_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);
	localparam int ITEM_W       = 8;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LEFT   = 2'd2;
	localparam logic [OP_W-1:0] OP_RIGHT  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // latch request payload
		logic ins_first;  // insert into empty list
		logic ins_rd;     // write new item, read cursor links
		logic ins_a;      // link new node to cursor and next
		logic ins_b;      // patch neighbors, move cursor
		logic scan;       // step lowest-free search
		logic del_upd;    // unlink cursor node
		logic move_upd;   // step cursor
		logic move_left;
		logic item_ld;    // load cursor item from memory
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic one;
		logic scan_hit;
	} sts_t;

endpackage

FILE: src/cclm_if.sv
interface cclm_req_if;
	import cclm_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ITEM_W-1:0] item;

	modport source(output valid, operation, item, input ready);
	modport sink(input valid, operation, item, output ready);
endinterface

interface cclm_rsp_if #(parameter int CNT_W = cclm_pkg::CNT_W_DEF);
	import cclm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ITEM_W-1:0]   removed_item;
	logic [ITEM_W-1:0]   cursor_item;
	logic [CNT_W-1:0]    item_count;
	logic                is_empty;
	logic                is_full;

	modport source(output valid, status, removed_item, cursor_item, item_count,
		is_empty, is_full, input ready);
	modport sink(input valid, status, removed_item, cursor_item, item_count,
		is_empty, is_full, output ready);
endinterface

FILE: src/cclm_ctrl.sv
module cclm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [cclm_pkg::OP_W-1:0]     req_op,
	output logic                          req_ready,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [cclm_pkg::STATUS_W-1:0] status,
	input  cclm_pkg::sts_t                sts,
	output cclm_pkg::cmd_t                cmd
);
	import cclm_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_INS_FIRST = 4'd1;
	localparam logic [3:0] S_INS_RD    = 4'd2;
	localparam logic [3:0] S_INS_A     = 4'd3;
	localparam logic [3:0] S_INS_B     = 4'd4;
	localparam logic [3:0] S_SCAN      = 4'd5;
	localparam logic [3:0] S_LINK_RD   = 4'd6;
	localparam logic [3:0] S_UPD       = 4'd7;
	localparam logic [3:0] S_ITEM_RD   = 4'd8;
	localparam logic [3:0] S_OUT       = 4'd9;

	logic [3:0]          state_q, state_d;
	logic [OP_W-1:0]     op_q;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                accept;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					status_d    = ST_DONE;
					if (req_op == OP_INSERT) begin
						if (sts.full) begin
							status_d = ST_FULL;
							state_d  = S_OUT;
						end else if (sts.empty) begin
							state_d = S_INS_FIRST;
						end else begin
							state_d = S_INS_RD;
						end
					end else if (sts.empty) begin
						status_d = ST_EMPTY;
						state_d  = S_OUT;
					end else begin
						state_d = S_LINK_RD;
					end
				end
			end
			S_INS_FIRST: begin
				cmd.ins_first = 1'b1;
				state_d       = S_SCAN;
			end
			S_INS_RD: begin
				cmd.ins_rd = 1'b1;
				state_d    = S_INS_A;
			end
			S_INS_A: begin
				cmd.ins_a = 1'b1;
				state_d   = S_INS_B;
			end
			S_INS_B: begin
				cmd.ins_b = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					state_d = S_OUT;
				end
			end
			S_LINK_RD: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (op_q == OP_DELETE) begin
					cmd.del_upd = 1'b1;
					state_d     = sts.one ? S_OUT : S_ITEM_RD;
				end else begin
					cmd.move_upd  = 1'b1;
					cmd.move_left = (op_q == OP_LEFT);
					state_d       = S_ITEM_RD;
				end
			end
			S_ITEM_RD: begin
				cmd.item_ld = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_DONE;
			op_q     <= OP_INSERT;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (accept) begin
				op_q <= req_op;
			end
		end
	end

endmodule

FILE: src/cclm_dp.sv
module cclm_dp #(
	parameter int CAPACITY = cclm_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cclm_pkg::cmd_t              cmd,
	input  logic [cclm_pkg::ITEM_W-1:0] req_item,
	output cclm_pkg::sts_t              sts,
	output logic [cclm_pkg::ITEM_W-1:0] removed_item,
	output logic [cclm_pkg::ITEM_W-1:0] cursor_item,
	output logic [CNT_W-1:0]            item_count,
	output logic                        is_empty,
	output logic                        is_full
);
	import cclm_pkg::*;

	localparam int SW = $clog2(CAPACITY);

	// node pool
	logic [ITEM_W-1:0] item_mem [CAPACITY];
	logic [SW-1:0]     fwd_mem  [CAPACITY];
	logic [SW-1:0]     bwd_mem  [CAPACITY];

	logic [ITEM_W-1:0] item_rd_q;
	logic [SW-1:0]     fwd_rd_q, bwd_rd_q;

	logic [CAPACITY-1:0] free_q;
	logic [SW-1:0]       cur_q, head_q, nx_q;
	logic [CNT_W-1:0]    cnt_q, low_q, scan_idx_q;
	logic [ITEM_W-1:0]   item_q, cur_item_q, removed_q;

	logic [SW-1:0]     n, nx, pv, newc;
	logic              item_we, fwd_we, bwd_we, scan_hit;
	logic [SW-1:0]     item_wa, fwd_wa, fwd_wd, bwd_wa, bwd_wd;

	assign n  = low_q[SW-1:0];
	assign nx = fwd_rd_q;
	assign pv = bwd_rd_q;

	assign scan_hit = (scan_idx_q == CNT_W'(CAPACITY)) || free_q[scan_idx_q[SW-1:0]];

	assign sts.empty    = (cnt_q == '0);
	assign sts.full     = (cnt_q == CNT_W'(CAPACITY));
	assign sts.one      = (cnt_q == CNT_W'(1));
	assign sts.scan_hit = scan_hit;

	assign removed_item = removed_q;
	assign cursor_item  = cur_item_q;
	assign item_count   = cnt_q;
	assign is_empty     = sts.empty;
	assign is_full      = sts.full;

	// next cursor for delete / move
	always_comb begin
		if (cmd.move_upd) begin
			newc = cmd.move_left ? pv : nx;
		end else if (head_q == cur_q) begin
			newc = nx;
		end else if (nx == head_q) begin
			newc = pv;
		end else begin
			newc = nx;
		end
	end

	// memory write selects
	always_comb begin
		item_we = cmd.ins_first || cmd.ins_rd;
		item_wa = n;
		fwd_we  = 1'b0;
		fwd_wa  = '0;
		fwd_wd  = '0;
		bwd_we  = 1'b0;
		bwd_wa  = '0;
		bwd_wd  = '0;
		priority if (cmd.ins_first) begin
			fwd_we = 1'b1; fwd_wa = n;     fwd_wd = n;
			bwd_we = 1'b1; bwd_wa = n;     bwd_wd = n;
		end else if (cmd.ins_a) begin
			fwd_we = 1'b1; fwd_wa = n;     fwd_wd = nx;
			bwd_we = 1'b1; bwd_wa = n;     bwd_wd = cur_q;
		end else if (cmd.ins_b) begin
			fwd_we = 1'b1; fwd_wa = cur_q; fwd_wd = n;
			bwd_we = 1'b1; bwd_wa = nx_q;  bwd_wd = n;
		end else if (cmd.del_upd && !sts.one) begin
			fwd_we = 1'b1; fwd_wa = pv;    fwd_wd = nx;
			bwd_we = 1'b1; bwd_wa = nx;    bwd_wd = pv;
		end else begin
			fwd_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_we) begin
			item_mem[item_wa] <= item_q;
		end
		item_rd_q <= item_mem[newc];
	end

	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
		end
		fwd_rd_q <= fwd_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (bwd_we) begin
			bwd_mem[bwd_wa] <= bwd_wd;
		end
		bwd_rd_q <= bwd_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= req_item;
		end
		if (cmd.ins_a) begin
			nx_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q     <= '1;
			cur_q      <= '0;
			head_q     <= '0;
			cnt_q      <= '0;
			low_q      <= '0;
			scan_idx_q <= '0;
			cur_item_q <= '0;
			removed_q  <= '0;
		end else begin
			if (cmd.load_in) begin
				removed_q <= '0;
			end
			if (cmd.ins_first || cmd.ins_b) begin
				cur_q      <= n;
				cnt_q      <= CNT_W'(cnt_q + CNT_W'(1));
				free_q[n]  <= 1'b0;
				cur_item_q <= item_q;
				scan_idx_q <= CNT_W'(low_q + CNT_W'(1));
			end
			if (cmd.ins_first) begin
				head_q <= n;
			end
			if (cmd.scan) begin
				if (scan_hit) begin
					low_q <= scan_idx_q;
				end else begin
					scan_idx_q <= CNT_W'(scan_idx_q + CNT_W'(1));
				end
			end
			if (cmd.del_upd) begin
				removed_q     <= cur_item_q;
				free_q[cur_q] <= 1'b1;
				cnt_q         <= CNT_W'(cnt_q - CNT_W'(1));
				if (CNT_W'(cur_q) < low_q) begin
					low_q <= CNT_W'(cur_q);
				end
				if (sts.one) begin
					cur_q      <= '0;
					head_q     <= '0;
					cur_item_q <= '0;
				end else begin
					cur_q <= newc;
					if (head_q == cur_q) begin
						head_q <= nx;
					end
				end
			end
			if (cmd.move_upd) begin
				cur_q <= newc;
			end
			if (cmd.item_ld) begin
				cur_item_q <= item_rd_q;
			end
		end
	end

endmodule

FILE: src/cursor_circular_list_manager_top.sv
// Cursor circular list manager: a bounded ring of byte items with a head
// and a cursor, held in a CAPACITY-slot node pool.
// req channel: one request = {operation, item}; taken when valid & ready.
//   insert places item after the cursor (lowest free slot), delete removes
//   the cursor node, move left / move right step the cursor.
// rsp channel: one response per request = {status, removed_item,
//   cursor_item, item_count, is_empty, is_full}.
// One request at a time: req.ready is high only while the block is idle.
// Steps from acceptance to rsp.valid:
//   refused request (insert when full, others when empty): straight to output
//   delete / move: link read, update, cursor item read;
//   delete of the last item: link read, update
//   insert: item write and link read, link, patch (one step for the first item),
//   then the lowest-free scan, which walks the free map one slot a cycle
//   from the used slot upward.
// The response register holds while rsp.ready is low; the next request is
// taken the cycle after the response is taken.
// Reset (arst_n low) empties the list: all slots free, count zero, no
// response pending. The node memories need no clearing.
module cursor_circular_list_manager_top #(
	parameter int CAPACITY = cclm_pkg::CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cclm_req_if.sink    req,
	cclm_rsp_if.source  rsp
);
	import cclm_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	cclm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.operation),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (rsp.status),
		.sts       (sts),
		.cmd       (cmd)
	);

	// node pool, links, free map and response fields
	cclm_dp #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_item     (req.item),
		.sts          (sts),
		.removed_item (rsp.removed_item),
		.cursor_item  (rsp.cursor_item),
		.item_count   (rsp.item_count),
		.is_empty     (rsp.is_empty),
		.is_full      (rsp.is_full)
	);

endmodule
